>>> rtl/frm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction to reduced mixed number: shared definitions
// Widths, operand select codes and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package frm_pkg;

   // Width of the signed numerator; the denominator is one bit narrower.
   localparam int DATA_WIDTH = 32;
   localparam int NUM_W      = DATA_WIDTH;
   localparam int DEN_W      = DATA_WIDTH - 1;

   // Step counter of the divider and common power-of-two count of the GCD.
   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam int SHF_W = $clog2(DEN_W + 1);

   // Operand pairs that the shared divider can be loaded with.
   typedef enum logic [1:0] {
      SEL_MAG,    // numerator magnitude / denominator
      SEL_FNUM,   // fractional numerator / gcd
      SEL_DEN     // denominator / gcd
   } div_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;       // capture a new transaction
      logic        clr_res;    // zero the result for a zero denominator
      logic        div_start;  // launch the divider
      div_sel_type div_sel;    // operands for that launch
      logic        cap_quo;    // take whole part and fractional numerator
      logic        set_int;    // fraction is zero: result 0/1
      logic        gcd_init;   // load the GCD registers
      logic        gcd_step;   // one binary GCD step
      logic        cap_rn;     // take the reduced numerator
      logic        cap_rd;     // take the reduced denominator
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic den_zero;
      logic fmag_zero;
      logic div_done;
      logic gcd_done;
   } dp_status_type;

endpackage

>>> rtl/frm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frm_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [frm_pkg::NUM_W-1:0] dividend,
   input  logic [frm_pkg::DEN_W-1:0] divisor,
   output logic                      done,
   output logic [frm_pkg::NUM_W-1:0] quotient,
   output logic [frm_pkg::DEN_W-1:0] remainder
);

   logic [frm_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      done_ff, done_in;
   logic [frm_pkg::NUM_W-1:0] dvd_ff, dvd_in;
   logic [frm_pkg::DEN_W-1:0] dvs_ff, dvs_in;
   logic [frm_pkg::DEN_W-1:0] rem_ff, rem_in;

   logic [frm_pkg::DEN_W:0]   trial;
   logic [frm_pkg::DEN_W:0]   diff;
   logic                      fits;

   // Shift the next dividend bit into the partial remainder and try a subtract.
   assign trial = {rem_ff, dvd_ff[frm_pkg::NUM_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   // Next-state logic; quotient bits enter the dividend register from the right.
   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         cnt_in = frm_pkg::CNT_W'(frm_pkg::NUM_W);
         dvd_in = dividend;
         dvs_in = divisor;
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == frm_pkg::CNT_W'(1));
         dvd_in  = {dvd_ff[frm_pkg::NUM_W-2:0], fits};
         rem_in  = fits ? diff[frm_pkg::DEN_W-1:0] : trial[frm_pkg::DEN_W-1:0];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // Operand registers.
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/frm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction to reduced mixed number: datapath
// Holds the transaction, the binary GCD registers, the shared divider and the
// result registers, and acts on the controller's commands.
// ----------------------------------------------------------------------------
module frm_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  frm_pkg::ctrl_cmd_type          cmd,
   output frm_pkg::dp_status_type         status,
   input  logic signed [frm_pkg::NUM_W-1:0] req_numerator_in,
   input  logic [frm_pkg::DEN_W-1:0]      req_denominator_in,
   output logic signed [frm_pkg::NUM_W-1:0] rsp_whole_part,
   output logic signed [frm_pkg::NUM_W-1:0] rsp_reduced_numerator,
   output logic [frm_pkg::DEN_W-1:0]      rsp_reduced_denominator
);

   localparam int NW = frm_pkg::NUM_W;
   localparam int DW = frm_pkg::DEN_W;

   logic [NW-1:0]             num_ff;
   logic [DW-1:0]             den_ff;
   logic [DW-1:0]             fmag_ff;
   logic                      fneg_ff;
   logic [DW-1:0]             ga_ff, gb_ff;
   logic [frm_pkg::SHF_W-1:0] gk_ff;
   logic [NW-1:0]             whole_ff;
   logic [NW-1:0]             rnum_ff;
   logic [DW-1:0]             rden_ff;

   logic                      neg;
   logic [NW-1:0]             mag;
   logic [DW-1:0]             gcd_val;
   logic [NW-1:0]             div_dvd;
   logic [DW-1:0]             div_dvs;
   logic                      div_done;
   logic [NW-1:0]             div_q;
   logic [DW-1:0]             div_r;

   // Sign and magnitude; the most negative value maps to 2^(NW-1) unsigned.
   assign neg = num_ff[NW-1];
   assign mag = neg ? (~num_ff + 1'b1) : num_ff;

   // The gcd is the odd remainder times the common power of two.
   assign gcd_val = ga_ff << gk_ff;

   // Operand selection for the shared divider.
   always_comb begin
      div_dvd = mag;
      div_dvs = den_ff;
      case (cmd.div_sel)
         frm_pkg::SEL_MAG: begin
            div_dvd = mag;
            div_dvs = den_ff;
         end
         frm_pkg::SEL_FNUM: begin
            div_dvd = {{(NW-DW){1'b0}}, fmag_ff};
            div_dvs = gcd_val;
         end
         frm_pkg::SEL_DEN: begin
            div_dvd = {{(NW-DW){1'b0}}, den_ff};
            div_dvs = gcd_val;
         end
         default: begin
            div_dvd = mag;
            div_dvs = den_ff;
         end
      endcase
   end

   frm_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // Transaction capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         num_ff <= req_numerator_in;
         den_ff <= req_denominator_in;
      end
   end

   // Fractional numerator after the first division.
   always_ff @(posedge clock) begin
      if (cmd.cap_quo) begin
         if (div_q != '0) begin
            fmag_ff <= div_r;
            fneg_ff <= 1'b0;
         end else begin
            fmag_ff <= mag[DW-1:0];
            fneg_ff <= neg;
         end
      end
   end

   // Binary GCD: strip common twos, then odd-odd subtraction until equal.
   always_ff @(posedge clock) begin
      if (cmd.gcd_init) begin
         ga_ff <= fmag_ff;
         gb_ff <= den_ff;
         gk_ff <= '0;
      end else if (cmd.gcd_step) begin
         if (!ga_ff[0] && !gb_ff[0]) begin
            ga_ff <= ga_ff >> 1;
            gb_ff <= gb_ff >> 1;
            gk_ff <= gk_ff + 1'b1;
         end else if (!ga_ff[0]) begin
            ga_ff <= ga_ff >> 1;
         end else if (!gb_ff[0]) begin
            gb_ff <= gb_ff >> 1;
         end else if (ga_ff > gb_ff) begin
            ga_ff <= ga_ff - gb_ff;
         end else begin
            gb_ff <= gb_ff - ga_ff;
         end
      end
   end

   // Result registers; the whole part is taken after the first division.
   always_ff @(posedge clock) begin
      if (cmd.clr_res) begin
         whole_ff <= '0;
         rnum_ff  <= '0;
         rden_ff  <= '0;
      end else begin
         if (cmd.cap_quo) begin
            whole_ff <= neg ? (~div_q + 1'b1) : div_q;
         end
         if (cmd.set_int) begin
            rnum_ff <= '0;
            rden_ff <= DW'(1);
         end
         if (cmd.cap_rn) begin
            rnum_ff <= fneg_ff ? (~div_q + 1'b1) : div_q;
         end
         if (cmd.cap_rd) begin
            rden_ff <= div_q[DW-1:0];
         end
      end
   end

   // Status back to the controller.
   assign status.den_zero  = (den_ff == '0);
   assign status.fmag_zero = (fmag_ff == '0);
   assign status.div_done  = div_done;
   assign status.gcd_done  = (ga_ff == gb_ff);

   assign rsp_whole_part          = whole_ff;
   assign rsp_reduced_numerator   = rnum_ff;
   assign rsp_reduced_denominator = rden_ff;

endmodule

>>> rtl/frm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction to reduced mixed number: controller
// Sequences the division, the GCD and the two reducing divisions, and raises
// the result strobe.
// ----------------------------------------------------------------------------
module frm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_strobe,
   input  frm_pkg::dp_status_type status,
   output frm_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WAIT_Q,
      ST_FRAC,
      ST_GCD,
      ST_WAIT_N,
      ST_WAIT_D
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   // Next state, strobe and commands.
   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      cmd       = '0;
      cmd.div_sel = frm_pkg::SEL_MAG;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.den_zero) begin
               cmd.clr_res = 1'b1;
               strobe_in   = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = frm_pkg::SEL_MAG;
               state_in      = ST_WAIT_Q;
            end
         end
         ST_WAIT_Q: begin
            if (status.div_done) begin
               cmd.cap_quo = 1'b1;
               state_in    = ST_FRAC;
            end
         end
         ST_FRAC: begin
            if (status.fmag_zero) begin
               cmd.set_int = 1'b1;
               strobe_in   = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.gcd_init = 1'b1;
               state_in     = ST_GCD;
            end
         end
         ST_GCD: begin
            if (status.gcd_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = frm_pkg::SEL_FNUM;
               state_in      = ST_WAIT_N;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_WAIT_N: begin
            if (status.div_done) begin
               cmd.cap_rn    = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = frm_pkg::SEL_DEN;
               state_in      = ST_WAIT_D;
            end
         end
         ST_WAIT_D: begin
            if (status.div_done) begin
               cmd.cap_rd = 1'b1;
               strobe_in  = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

>>> rtl/fraction_to_reduced_mixed_number.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction to reduced mixed number
// Turns a signed fraction into a whole part and a fraction in lowest terms.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result is
// shown for exactly one cycle with rsp_strobe high, and the receiver cannot
// stall it, so it must take every strobe. One transaction is worked at a
// time. A zero denominator gives an all-zero result. Otherwise the shared
// bit-serial divider first gives the whole part, then a binary GCD runs one
// step per cycle, then two more divisions reduce the fractional numerator
// and the denominator by the gcd. When the fraction is zero the GCD and
// the last two divisions are skipped. busy drops in the cycle of the strobe,
// so the next transaction may be started then.
// ----------------------------------------------------------------------------
module fraction_to_reduced_mixed_number (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [frm_pkg::NUM_W-1:0] req_numerator_in,
   input  logic [frm_pkg::DEN_W-1:0]        req_denominator_in,
   output logic                             rsp_strobe,
   output logic signed [frm_pkg::NUM_W-1:0] rsp_whole_part,
   output logic signed [frm_pkg::NUM_W-1:0] rsp_reduced_numerator,
   output logic [frm_pkg::DEN_W-1:0]        rsp_reduced_denominator
);

   frm_pkg::ctrl_cmd_type  cmd;
   frm_pkg::dp_status_type status;

   // Sequencer.
   frm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .status     (status),
      .cmd        (cmd)
   );

   // Arithmetic and result registers.
   frm_datapath u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_numerator_in        (req_numerator_in),
      .req_denominator_in      (req_denominator_in),
      .rsp_whole_part          (rsp_whole_part),
      .rsp_reduced_numerator   (rsp_reduced_numerator),
      .rsp_reduced_denominator (rsp_reduced_denominator)
   );

endmodule
